>>> rtl/core/mrds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum rate deadline search package
// Sizes, request and result types, and the sequencer state type that the
// block's modules share.
// ----------------------------------------------------------------------------
package mrds_pkg;

    localparam int MAX_JOBS   = 1024;
    localparam int SIZE_WIDTH = 16;
    localparam int BUDGET_W   = 26;
    localparam int ADDR_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int COUNT_W    = $clog2(MAX_JOBS + 1);
    localparam int ACC_W      = COUNT_W + SIZE_WIDTH;
    localparam int CMP_W      = (ACC_W > BUDGET_W) ? ACC_W : BUDGET_W;
    localparam int RATE_W     = SIZE_WIDTH + 1;
    localparam int STEP_W     = $clog2(SIZE_WIDTH + 1);
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TIME_BUDGET = '0;
    localparam logic [BUDGET_W-1:0]  BUDGET_RESET    = BUDGET_W'(1);

    typedef struct packed {
        logic [SIZE_WIDTH-1:0] job_size;
        logic                  last_job;
    } job_t;

    typedef struct packed {
        logic [SIZE_WIDTH-1:0] min_rate;
        logic                  overflow;
    } result_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [SIZE_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic                  start;
        logic [SIZE_WIDTH-1:0] dividend;
        logic [SIZE_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [SIZE_WIDTH-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROUND,
        ST_DIVIDE,
        ST_WAIT,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/mrds_job_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Job size store
// Single-port-write, single-port-read memory of job sizes with registered
// read data.
// ----------------------------------------------------------------------------
module mrds_job_store
    import mrds_pkg::*;
(
    input  wire logic                  clk,
    input  wire mem_req_t              mem_req,
    output logic [SIZE_WIDTH-1:0]      rd_data
);

    logic [SIZE_WIDTH-1:0] mem [MAX_JOBS];
    logic [SIZE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> rtl/core/mrds_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ceiling divider
// Restoring divider producing one quotient bit per cycle; the result is
// rounded up when the remainder is non-zero.
// ----------------------------------------------------------------------------
module mrds_divider
    import mrds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t div_req,
    output div_rsp_t      div_rsp
);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [SIZE_WIDTH-1:0] rem_reg;
    logic [SIZE_WIDTH-1:0] rem_next;
    logic [SIZE_WIDTH-1:0] quo_reg;
    logic [SIZE_WIDTH-1:0] quo_next;
    logic [SIZE_WIDTH-1:0] dvs_reg;
    logic [SIZE_WIDTH-1:0] dvs_next;
    logic [SIZE_WIDTH:0]   shifted;
    logic [SIZE_WIDTH:0]   diff;
    logic                  fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[SIZE_WIDTH-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (div_req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SIZE_WIDTH);
            rem_next  = '0;
            quo_next  = div_req.dividend;
            dvs_next  = div_req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[SIZE_WIDTH-1:0] : shifted[SIZE_WIDTH-1:0];
            quo_next  = {quo_reg[SIZE_WIDTH-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg + SIZE_WIDTH'(rem_reg != '0);

endmodule
`default_nettype wire

>>> rtl/core/mrds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Search sequencer
// Loads the job set, runs the binary search over rates with the shared
// divider, accumulates the totals and holds the result register.
// ----------------------------------------------------------------------------
module mrds_ctrl
    import mrds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    output logic                       job_ready,
    input  wire job_t                  job,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result,
    input  wire logic [BUDGET_W-1:0]   time_budget,
    output mem_req_t                   mem_req,
    input  wire logic [SIZE_WIDTH-1:0] mem_rd_data,
    output div_req_t                   div_req,
    input  wire div_rsp_t              div_rsp
);

    state_t                state_reg;
    state_t                state_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [SIZE_WIDTH-1:0] largest_reg;
    logic [SIZE_WIDTH-1:0] largest_next;
    logic                  dropped_reg;
    logic                  dropped_next;
    logic [RATE_W-1:0]     low_reg;
    logic [RATE_W-1:0]     low_next;
    logic [RATE_W-1:0]     high_reg;
    logic [RATE_W-1:0]     high_next;
    logic [SIZE_WIDTH-1:0] mid_reg;
    logic [SIZE_WIDTH-1:0] mid_next;
    logic [SIZE_WIDTH-1:0] best_reg;
    logic [SIZE_WIDTH-1:0] best_next;
    logic [ACC_W-1:0]      total_reg;
    logic [ACC_W-1:0]      total_next;
    logic [COUNT_W-1:0]    idx_reg;
    logic [COUNT_W-1:0]    idx_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    result_t               result_reg;
    logic                  load_result;
    logic [RATE_W:0]       range_sum;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        largest_next = largest_reg;
        dropped_next = dropped_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        mid_next     = mid_reg;
        best_next    = best_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        load_result  = 1'b0;
        job_ready    = 1'b0;
        range_sum    = {1'b0, low_reg} + {1'b0, high_reg};

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = count_reg[ADDR_W-1:0];
        mem_req.wr_data = job.job_size;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = '0;

        div_req.start    = 1'b0;
        div_req.dividend = mem_rd_data;
        div_req.divisor  = mid_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    if (count_reg < COUNT_W'(MAX_JOBS))
                    begin
                        mem_req.wr_en = 1'b1;
                        count_next    = count_reg + COUNT_W'(1);
                        if (job.job_size > largest_reg)
                        begin
                            largest_next = job.job_size;
                        end
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (job.last_job)
                    begin
                        low_next   = RATE_W'(1);
                        high_next  = {1'b0, largest_next};
                        best_next  = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                if (low_reg <= high_reg)
                begin
                    mid_next        = range_sum[SIZE_WIDTH:1];
                    idx_next        = '0;
                    total_next      = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = '0;
                    state_next      = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIVIDE:
            begin
                div_req.start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    total_next = total_reg + ACC_W'(div_rsp.quotient);
                    idx_next   = idx_reg + COUNT_W'(1);
                    if (idx_next == count_reg)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_next[ADDR_W-1:0];
                        state_next      = ST_DIVIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (CMP_W'(total_reg) <= CMP_W'(time_budget))
                begin
                    best_next = mid_reg;
                    high_next = {1'b0, mid_reg} - RATE_W'(1);
                end
                else
                begin
                    low_next = {1'b0, mid_reg} + RATE_W'(1);
                end
                state_next = ST_ROUND;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load_result  = 1'b1;
                    count_next   = '0;
                    largest_next = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        result_valid_next = (result_valid_reg && !result_ready) || load_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            largest_reg      <= '0;
            dropped_reg      <= 1'b0;
            low_reg          <= RATE_W'(1);
            high_reg         <= '0;
            best_reg         <= '0;
            total_reg        <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            largest_reg      <= largest_next;
            dropped_reg      <= dropped_next;
            low_reg          <= low_next;
            high_reg         <= high_next;
            best_reg         <= best_next;
            total_reg        <= total_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        if (load_result)
        begin
            result_reg.min_rate <= best_reg;
            result_reg.overflow <= dropped_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

>>> rtl/core/min_rate_deadline_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Minimum rate deadline search
// Finds the smallest service rate whose summed ceiling job times fit the
// configured time budget.
// ----------------------------------------------------------------------------
// Outside a search, a request that does not close a set is taken as soon as
// it is valid. The request marked last_job starts the search, and no further
// request is taken until its result has been placed in the output register:
// the search runs R rounds, R being at most 16 (the bit length of the largest
// size), and in each round every stored job passes in turn through the single
// shared divider, which retires one quotient bit per cycle. Up to 1024 jobs
// are stored; later jobs of the same set are dropped and the result reports
// overflow. The budget register sits at address 0 and resets to 1.
// ----------------------------------------------------------------------------
module min_rate_deadline_search
    import mrds_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  wire job_t               job,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output result_t                 result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic [BUDGET_W-1:0]   budget_reg;
    logic [BUDGET_W-1:0]   budget_next;
    logic [REG_IDX_W-1:0]  reg_index;
    mem_req_t              mem_req;
    logic [SIZE_WIDTH-1:0] mem_rd_data;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];

    always_comb
    begin
        budget_next = budget_reg;
        prdata      = '0;
        unique case (reg_index)
            REG_TIME_BUDGET:
            begin
                prdata = PDATA_W'(budget_reg);
                if (psel && penable && pwrite)
                begin
                    budget_next = pwdata[BUDGET_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
        end
        else
        begin
            budget_reg <= budget_next;
        end
    end

    mrds_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .time_budget  (budget_reg),
        .mem_req      (mem_req),
        .mem_rd_data  (mem_rd_data),
        .div_req      (div_req),
        .div_rsp      (div_rsp)
    );

    mrds_job_store u_job_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (mem_rd_data)
    );

    mrds_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

endmodule
`default_nettype wire

>>> rtl/core/mrds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the request and result ports of the search block.
// ----------------------------------------------------------------------------
module mrds_checker
    import mrds_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    job_valid,
    input  wire logic    job_ready,
    input  wire job_t    job,
    input  wire logic    result_valid,
    input  wire logic    result_ready,
    input  wire result_t result
);

    // A waiting result keeps its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Accepting the request that closes a set starts the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready && job.last_job |=> !job_ready)
        else $error("request taken during search");

    // The block only stops taking requests after a closing request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(job_ready) |-> $past(job_valid && job.last_job))
        else $error("ready dropped without a closing request");

    // A new result appears exactly as the block reopens for requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $rose(job_ready))
        else $error("result appeared outside the end of a search");

endmodule

bind min_rate_deadline_search mrds_checker u_mrds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
`default_nettype wire
